// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the cursor engine and the result
// buffer. They compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// File: hw/rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// Text console cursor writer package
// Screen geometry, character and result codes, item types, and the address
// helpers used by the cursor engine.
// ----------------------------------------------------------------------------
package tccw_pkg;

   localparam int COLUMNS  = 80;
   localparam int ROWS     = 25;
   localparam int TAB_STOP = 8;

   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int ADDR_W = 11;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int KIND_W = 2;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd240;

   localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd127;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

   localparam logic [KIND_W-1:0] KIND_CURSOR = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CELL   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   localparam logic MODE_PUT_CHAR = 1'b0;
   localparam logic MODE_SET_POS  = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [CHAR_W-1:0] char_code;
      logic [ROW_W-1:0]  new_row;
      logic [COL_W-1:0]  new_col;
   } req_item_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] cell_addr;
      logic [CHAR_W-1:0] cell_char;
      logic [ATTR_W-1:0] cell_attr;
      logic [ADDR_W-1:0] cursor_addr;
      logic [ROW_W-1:0]  start_row;
      logic              last;
   } rsp_item_type;

   typedef struct packed {
      rsp_item_type first;
      rsp_item_type second;
      logic         two;
   } result_pair_type;

   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                 input logic [ROW_W-1:0] row);
      logic [ROW_W:0] sum;
      sum = {1'b0, top} + {1'b0, row};
      if (sum >= (ROW_W+1)'(ROWS)) begin
         sum = sum - (ROW_W+1)'(ROWS);
      end
      return sum[ROW_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_index(input logic [ROW_W-1:0] prow,
                                                    input logic [COL_W-1:0] col);
      return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
   endfunction

endpackage

// File: hw/rtl/text_console_cursor_writer.sv
// ----------------------------------------------------------------------------
// Text console cursor writer
// Interprets character and cursor items for an 80x25 ring-scrolled text
// screen and issues cell writes, row clears and cursor updates.
// ----------------------------------------------------------------------------
// An item goes into an input register, is worked out in one combinational
// pass by the cursor engine and lands in a two-entry result register, from
// which its first result is handed out. For items that give one result (a
// cursor update or a single cell write), a new item can be accepted every
// cycle while results are taken; a printable character that scrolls gives a
// cell write and a row clear, handed out one per cycle while results are
// taken. Scrolling only moves the ring start row and clears the new bottom
// row. The attribute register must be written through the csr port only
// while the block is idle; the block itself does not enforce this.

module text_console_cursor_writer
   import tccw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_mode,
   input  logic [CHAR_W-1:0]   req_char_code,
   input  logic [ROW_W-1:0]    req_new_row,
   input  logic [COL_W-1:0]    req_new_col,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [ADDR_W-1:0]   rsp_cell_addr,
   output logic [CHAR_W-1:0]   rsp_cell_char,
   output logic [ATTR_W-1:0]   rsp_cell_attr,
   output logic [ADDR_W-1:0]   rsp_cursor_addr,
   output logic [ROW_W-1:0]    rsp_start_row,
   output logic                rsp_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [ATTR_W-1:0]   csr_text_attribute
);

   logic            in_valid_ff, in_valid_in;
   req_item_type    in_item_ff, in_item_in;
   logic [ATTR_W-1:0] attr_ff, attr_in;
   logic            can_take;
   logic            advance;
   logic            req_take;
   result_pair_type pair;
   rsp_item_type    rsp_item;

   assign advance   = in_valid_ff && can_take;
   assign req_stall = in_valid_ff && !can_take;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      attr_in     = attr_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_item_in  = '{mode: req_mode, char_code: req_char_code,
                         new_row: req_new_row, new_col: req_new_col};
      end
      if (csr_valid && csr_ready) begin
         attr_in = csr_text_attribute;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         attr_ff     <= ATTR_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         attr_ff     <= attr_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   tccw_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .item    (in_item_ff),
      .advance (advance),
      .attr    (attr_ff),
      .results (pair)
   );

   tccw_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .pair      (pair),
      .can_take  (can_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_kind        = rsp_item.kind;
   assign rsp_cell_addr   = rsp_item.cell_addr;
   assign rsp_cell_char   = rsp_item.cell_char;
   assign rsp_cell_attr   = rsp_item.cell_attr;
   assign rsp_cursor_addr = rsp_item.cursor_addr;
   assign rsp_start_row   = rsp_item.start_row;
   assign rsp_last        = rsp_item.last;

endmodule

// File: hw/rtl/tccw_engine.sv
// ----------------------------------------------------------------------------
// Cursor engine
// Holds the cursor and ring offset and turns one registered item into its
// one or two results in a single combinational pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tccw_engine
   import tccw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  req_item_type    item,
   input  logic            advance,
   input  logic [ATTR_W-1:0] attr,
   output result_pair_type results
);

   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] top_ff, top_in;

   logic [COL_W-1:0] tab_q;
   logic [COL_W:0]   tab_col;
   logic [COL_W:0]   col_inc;
   logic [ROW_W-1:0] top_next;
   logic             new_line;
   logic             scroll;
   logic             scroll_taken;
   logic             write_cell;
   logic [ROW_W-1:0] wr_row;
   logic [COL_W-1:0] wr_col;
   logic [CHAR_W-1:0] wr_char;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] clr_addr;
   logic [ADDR_W-1:0] cur_addr;
   rsp_item_type     cell_res;
   rsp_item_type     clr_res;
   rsp_item_type     cur_res;

   assign tab_q    = COL_W'(col_ff / COL_W'(TAB_STOP));
   assign tab_col  = (COL_W+1)'(({1'b0, tab_q} + (COL_W+1)'(1)) * (COL_W+1)'(TAB_STOP));
   assign col_inc  = {1'b0, col_ff} + (COL_W+1)'(1);
   assign top_next = phys_row(top_ff, ROW_W'(1));

   always_comb begin
      row_in     = row_ff;
      col_in     = col_ff;
      top_in     = top_ff;
      new_line   = 1'b0;
      scroll     = 1'b0;
      write_cell = 1'b0;
      wr_row     = row_ff;
      wr_col     = col_ff;
      wr_char    = item.char_code;
      if (item.mode == MODE_SET_POS) begin
         row_in = (item.new_row < ROW_W'(ROWS)) ? item.new_row : ROW_W'(ROWS - 1);
         col_in = (item.new_col < COL_W'(COLUMNS)) ? item.new_col : COL_W'(COLUMNS - 1);
      end else begin
         case (item.char_code)
            CH_TAB: begin
               if (tab_col >= (COL_W+1)'(COLUMNS)) begin
                  new_line = 1'b1;
               end else begin
                  col_in = tab_col[COL_W-1:0];
               end
            end
            CH_NEWLINE: begin
               new_line = 1'b1;
            end
            CH_BACKSPACE: begin
               wr_char = CH_SPACE;
               if (col_ff != '0) begin
                  col_in     = col_ff - COL_W'(1);
                  write_cell = 1'b1;
               end else if (row_ff != '0) begin
                  row_in     = row_ff - ROW_W'(1);
                  col_in     = COL_W'(COLUMNS - 1);
                  write_cell = 1'b1;
               end
               wr_row = row_in;
               wr_col = col_in;
            end
            default: begin
               write_cell = 1'b1;
               if (col_inc >= (COL_W+1)'(COLUMNS)) begin
                  new_line = 1'b1;
               end else begin
                  col_in = col_inc[COL_W-1:0];
               end
            end
         endcase
         if (new_line) begin
            col_in = '0;
            if (row_ff >= ROW_W'(ROWS - 1)) begin
               row_in = ROW_W'(ROWS - 1);
               top_in = top_next;
               scroll = 1'b1;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end
      end
   end

   assign scroll_taken = advance && scroll;

   assign wr_addr  = cell_index(phys_row(top_ff, wr_row), wr_col);
   assign clr_addr = cell_index(phys_row(top_in, ROW_W'(ROWS - 1)), '0);
   assign cur_addr = cell_index(phys_row(top_in, row_in), col_in);

   always_comb begin
      cell_res = '{kind: KIND_CELL, cell_addr: wr_addr, cell_char: wr_char,
                   cell_attr: attr, cursor_addr: cur_addr, start_row: top_in,
                   last: !scroll};
      clr_res  = '{kind: KIND_CLEAR, cell_addr: clr_addr, cell_char: CH_SPACE,
                   cell_attr: attr, cursor_addr: cur_addr, start_row: top_in,
                   last: 1'b1};
      cur_res  = '{kind: KIND_CURSOR, cell_addr: '0, cell_char: '0, cell_attr: '0,
                   cursor_addr: cur_addr, start_row: top_in, last: 1'b1};
      results.second = clr_res;
      results.two    = write_cell && scroll;
      if (write_cell) begin
         results.first = cell_res;
      end else if (scroll) begin
         results.first = clr_res;
      end else begin
         results.first = cur_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         top_ff <= '0;
      end else if (advance) begin
         row_ff <= row_in;
         col_ff <= col_in;
         top_ff <= top_in;
      end
   end

   `ASSERT_NEVER(a_row_range, clock, reset, row_ff >= ROW_W'(ROWS))
   `ASSERT_NEVER(a_col_range, clock, reset, col_ff >= COL_W'(COLUMNS))
   `ASSERT_IMPLIES(a_top_step, clock, reset, $past(scroll_taken), top_ff == $past(top_next))

endmodule

// File: hw/rtl/tccw_rsp_buf.sv
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry result register that takes the results of one item at once and
// hands them out one per handshake.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tccw_rsp_buf
   import tccw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  result_pair_type pair,
   output logic            can_take,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_item_type    rsp_item
);

   rsp_item_type slot0_ff, slot0_in;
   rsp_item_type slot1_ff, slot1_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign can_take  = (count_ff == 2'd0) || ((count_ff == 2'd1) && pop);
   assign rsp_item  = slot0_ff;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (push) begin
         slot0_in = pair.first;
         slot1_in = pair.second;
         count_in = pair.two ? 2'd2 : 2'd1;
      end else if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   `ASSERT_NEVER(a_count_range, clock, reset, count_ff == 2'd3)
   `ASSERT_IMPLIES(a_first_not_last, clock, reset, count_ff == 2'd2, !slot0_ff.last && slot1_ff.last)
   `ASSERT_IMPLIES(a_single_last, clock, reset, count_ff == 2'd1, slot0_ff.last)

endmodule

// File: dv/tb_text_console_cursor_writer.sv
// ----------------------------------------------------------------------------
// Text console cursor writer testbench
// Drives character and cursor items into the writer with random idle gaps on
// both sides and checks every cell write, row clear and cursor update. The
// expected results come from a tracker of the cursor, the ring start row and
// the attribute. The attribute is rewritten between phases while the writer
// is idle. One phase holds the result side off long enough to back the
// writer up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_text_console_cursor_writer;
   import tccw_pkg::*;

   class screen_tracker;
      int row;
      int col;
      int top;
      logic [ATTR_W-1:0] attr;
      rsp_item_type due_results[$];
      rsp_item_type batch[$];

      function new();
         row = 0;
         col = 0;
         top = 0;
         attr = ATTR_RESET;
      endfunction

      function void set_attribute(input logic [ATTR_W-1:0] value);
         attr = value;
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      function int screen_row(input int logical);
         return (top + logical) % ROWS;
      endfunction

      function void add_result(input logic [KIND_W-1:0] kind, input int addr,
                               input logic [CHAR_W-1:0] ch, input logic [ATTR_W-1:0] at);
         rsp_item_type r;
         r = '0;
         r.kind = kind;
         r.cell_addr = ADDR_W'(addr);
         r.cell_char = ch;
         r.cell_attr = at;
         batch.push_back(r);
      endfunction

      function void line_feed();
         col = 0;
         if (row >= ROWS - 1) begin
            row = ROWS - 1;
            top = (top + 1) % ROWS;
            add_result(KIND_CLEAR, screen_row(row) * COLUMNS, CH_SPACE, attr);
         end else begin
            row++;
         end
      endfunction

      function void take_input(input req_item_type it);
         rsp_item_type r;
         int k;
         batch.delete();
         if (it.mode == MODE_SET_POS) begin
            row = (it.new_row < ROWS) ? int'(it.new_row) : ROWS - 1;
            col = (it.new_col < COLUMNS) ? int'(it.new_col) : COLUMNS - 1;
         end else if (it.char_code == CH_TAB) begin
            col = (col / TAB_STOP + 1) * TAB_STOP;
            if (col >= COLUMNS) begin
               line_feed();
            end
         end else if (it.char_code == CH_NEWLINE) begin
            line_feed();
         end else if (it.char_code == CH_BACKSPACE) begin
            if (col > 0) begin
               col--;
               add_result(KIND_CELL, screen_row(row) * COLUMNS + col, CH_SPACE, attr);
            end else if (row > 0) begin
               row--;
               col = COLUMNS - 1;
               add_result(KIND_CELL, screen_row(row) * COLUMNS + col, CH_SPACE, attr);
            end
         end else begin
            add_result(KIND_CELL, screen_row(row) * COLUMNS + col, it.char_code, attr);
            col++;
            if (col >= COLUMNS) begin
               line_feed();
            end
         end
         if (batch.size() == 0) begin
            add_result(KIND_CURSOR, 0, '0, '0);
         end
         for (k = 0; k < batch.size(); k++) begin
            r = batch[k];
            r.cursor_addr = ADDR_W'(screen_row(row) * COLUMNS + col);
            r.start_row = ROW_W'(top);
            r.last = (k == batch.size() - 1);
            due_results.push_back(r);
         end
      endfunction

      function string check_result(input rsp_item_type got);
         rsp_item_type want;
         string msg;
         if (due_results.size() == 0) begin
            return "result arrived with none expected";
         end
         want = due_results.pop_front();
         msg = "";
         if (got.kind != want.kind)
            msg = {msg, $sformatf(" kind %0d/%0d", want.kind, got.kind)};
         if (got.cell_addr != want.cell_addr)
            msg = {msg, $sformatf(" cell_addr %0d/%0d", want.cell_addr, got.cell_addr)};
         if (got.cell_char != want.cell_char)
            msg = {msg, $sformatf(" cell_char %0d/%0d", want.cell_char, got.cell_char)};
         if (got.cell_attr != want.cell_attr)
            msg = {msg, $sformatf(" cell_attr %0d/%0d", want.cell_attr, got.cell_attr)};
         if (got.cursor_addr != want.cursor_addr)
            msg = {msg, $sformatf(" cursor_addr %0d/%0d", want.cursor_addr, got.cursor_addr)};
         if (got.start_row != want.start_row)
            msg = {msg, $sformatf(" start_row %0d/%0d", want.start_row, got.start_row)};
         if (got.last != want.last)
            msg = {msg, $sformatf(" last %0d/%0d", want.last, got.last)};
         if (msg != "") begin
            msg = {"field expected/got:", msg};
         end
         return msg;
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_mode = 1'b0;
   logic [CHAR_W-1:0] req_char_code = '0;
   logic [ROW_W-1:0]  req_new_row = '0;
   logic [COL_W-1:0]  req_new_col = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [KIND_W-1:0] rsp_kind;
   logic [ADDR_W-1:0] rsp_cell_addr;
   logic [CHAR_W-1:0] rsp_cell_char;
   logic [ATTR_W-1:0] rsp_cell_attr;
   logic [ADDR_W-1:0] rsp_cursor_addr;
   logic [ROW_W-1:0]  rsp_start_row;
   logic              rsp_last;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [ATTR_W-1:0] csr_text_attribute = '0;

   screen_tracker tracker = new();
   int mismatch_count = 0;
   bit send_quiet = 1'b0;
   bit take_quiet = 1'b0;
   bit long_hold_due = 1'b0;

   text_console_cursor_writer u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_char_code      (req_char_code),
      .req_new_row        (req_new_row),
      .req_new_col        (req_new_col),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_cell_addr      (rsp_cell_addr),
      .rsp_cell_char      (rsp_cell_char),
      .rsp_cell_attr      (rsp_cell_attr),
      .rsp_cursor_addr    (rsp_cursor_addr),
      .rsp_start_row      (rsp_start_row),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_text_attribute (csr_text_attribute)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic flag_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_item(input req_item_type it);
      int gap;
      req_valid <= 1'b1;
      req_mode <= it.mode;
      req_char_code <= it.char_code;
      req_new_row <= it.new_row;
      req_new_col <= it.new_col;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_input(it);
      gap = send_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic put(input logic mode, input logic [CHAR_W-1:0] ch,
                      input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
      req_item_type it;
      it.mode = mode;
      it.char_code = ch;
      it.new_row = r;
      it.new_col = c;
      send_item(it);
   endtask

   function automatic req_item_type random_item();
      req_item_type it;
      int pick;
      it.mode = MODE_PUT_CHAR;
      it.char_code = CHAR_W'($urandom_range(0, 255));
      it.new_row = ROW_W'($urandom_range(0, 31));
      it.new_col = COL_W'($urandom_range(0, 127));
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         it.mode = MODE_SET_POS;
         if ($urandom_range(0, 3) != 0) begin
            it.new_row = ROW_W'($urandom_range(0, ROWS - 1));
            it.new_col = COL_W'($urandom_range(0, COLUMNS - 1));
         end
      end else if (pick < 20) begin
         it.char_code = CH_TAB;
      end else if (pick < 28) begin
         it.char_code = CH_NEWLINE;
      end else if (pick < 38) begin
         it.char_code = CH_BACKSPACE;
      end
      return it;
   endfunction

   task automatic run_random(input int count);
      repeat (count) send_item(random_item());
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_attribute(input logic [ATTR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_text_attribute <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      tracker.set_attribute(value);
   endtask

   always @(posedge clock) begin
      rsp_item_type got;
      string msg;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = rsp_kind;
         got.cell_addr = rsp_cell_addr;
         got.cell_char = rsp_cell_char;
         got.cell_attr = rsp_cell_attr;
         got.cursor_addr = rsp_cursor_addr;
         got.start_row = rsp_start_row;
         got.last = rsp_last;
         msg = tracker.check_result(got);
         if (msg != "") begin
            flag_mismatch(msg);
         end
      end
   end

   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (take_quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            gap = pick_gap();
            rsp_stall <= (gap != 0);
            if (gap > 1) begin
               repeat (gap - 1) @(posedge clock);
            end
         end
      end
   end

   initial begin
      #4000000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      put(MODE_PUT_CHAR, CH_BACKSPACE, 5'd0, 7'd0);
      put(MODE_PUT_CHAR, 8'h41, 5'd31, 7'd127);
      put(MODE_PUT_CHAR, 8'hFF, 5'd0, 7'd0);
      put(MODE_PUT_CHAR, 8'h00, 5'd0, 7'd0);
      put(MODE_PUT_CHAR, CH_TAB, 5'd0, 7'd0);
      put(MODE_PUT_CHAR, CH_TAB, 5'd0, 7'd0);
      put(MODE_SET_POS, 8'hFF, 5'd0, 7'd77);
      put(MODE_PUT_CHAR, CH_TAB, 5'd0, 7'd0);
      put(MODE_PUT_CHAR, CH_BACKSPACE, 5'd0, 7'd0);
      put(MODE_PUT_CHAR, CH_NEWLINE, 5'd0, 7'd0);
      put(MODE_SET_POS, 8'h00, 5'd31, 7'd127);
      put(MODE_PUT_CHAR, 8'h7E, 5'd0, 7'd0);
      put(MODE_PUT_CHAR, CH_NEWLINE, 5'd0, 7'd0);
      put(MODE_SET_POS, CH_TAB, 5'd24, 7'd75);
      put(MODE_PUT_CHAR, CH_TAB, 5'd0, 7'd0);
      put(MODE_SET_POS, CH_BACKSPACE, 5'd24, 7'd0);
      put(MODE_PUT_CHAR, CH_BACKSPACE, 5'd0, 7'd0);
      put(MODE_SET_POS, CH_NEWLINE, 5'd25, 7'd80);
      put(MODE_PUT_CHAR, CH_SPACE, 5'd0, 7'd0);
      put(MODE_SET_POS, 8'h00, 5'd16, 7'd64);
      put(MODE_PUT_CHAR, 8'h80, 5'd0, 7'd0);
      put(MODE_PUT_CHAR, CH_BACKSPACE, 5'd0, 7'd0);
      put(MODE_SET_POS, 8'h00, 5'd0, 7'd0);
      put(MODE_PUT_CHAR, CH_BACKSPACE, 5'd0, 7'd0);

      settle();
      write_attribute(8'h00);
      run_random(400);

      settle();
      write_attribute(8'hFF);
      run_random(200);
      send_quiet = 1'b1;
      take_quiet = 1'b1;
      run_random(200);
      take_quiet = 1'b0;
      long_hold_due = 1'b1;
      run_random(150);
      send_quiet = 1'b0;
      settle();
      run_random(150);

      settle();
      write_attribute(ATTR_W'($urandom_range(1, 254)));
      run_random(450);

      settle();
      write_attribute(8'h5A);
      run_random(450);

      settle();
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/tccw_pkg.sv
hw/rtl/tccw_engine.sv
hw/rtl/tccw_rsp_buf.sv
hw/rtl/text_console_cursor_writer.sv
dv/tb_text_console_cursor_writer.sv
